// ===== rtl/biquad_lowpass_tdf2_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef BIQUAD_LOWPASS_TDF2_UNIT_DEFINES_SVH
`define BIQUAD_LOWPASS_TDF2_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define BQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/bq_pkg.sv =====
`timescale 1ns / 1ps

package bq_pkg;

  localparam int COEF_WIDTH    = 26;
  localparam int ACC_WIDTH     = 48;
  localparam int CHAN_WIDTH    = 1;
  localparam int CFG_IDX_WIDTH = 2;

  localparam int DEF_NUM_CHANNELS   = 2;
  localparam int DEF_SAMPLE_WIDTH   = 24;
  localparam int DEF_COEF_FRAC_BITS = 22;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_FEED_OUTER  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FEED_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BACK_FIRST  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BACK_SECOND = 2'd3;

  typedef enum logic [1:0] {
    MUL_X_OUTER,
    MUL_X_MIDDLE,
    MUL_Y_BACK1,
    MUL_Y_BACK2
  } bq_mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_PROD_D1,
    ACC_PROD_D2,
    ACC_SUB_PROD,
    ACC_XA_SUB_PROD
  } bq_acc_op_e;

  typedef struct packed {
    logic        ld_in;
    logic        mul_en;
    bq_mul_sel_e mul_sel;
    bq_acc_op_e  acc_op;
    logic        ld_xa;
    logic        ld_y;
    logic        wr_d1;
    logic        wr_d2;
  } bq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } bq_sts_t;

endpackage

// ===== rtl/bq_if.sv =====
`timescale 1ns / 1ps

interface bq_in_if import bq_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic        [CHAN_WIDTH-1:0]   channel_in;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, channel_in, sample_in, input ready);
  modport sink   (input valid, channel_in, sample_in, output ready);
endinterface

interface bq_out_if import bq_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic        [CHAN_WIDTH-1:0]   channel_out;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

// ===== rtl/bq_ctrl.sv =====
`timescale 1ns / 1ps

module bq_ctrl import bq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  bq_sts_t sts_i,
  output bq_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XA   = 3'd1;
  localparam logic [2:0] ST_XM   = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_B1   = 3'd4;
  localparam logic [2:0] ST_B2   = 3'd5;
  localparam logic [2:0] ST_W1   = 3'd6;
  localparam logic [2:0] ST_W2   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{ld_in: 1'b0, mul_en: 1'b0, mul_sel: MUL_X_OUTER, acc_op: ACC_HOLD,
                ld_xa: 1'b0, ld_y: 1'b0, wr_d1: 1'b0, wr_d2: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_XA;
        end
      end
      ST_XA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X_OUTER;
        state_d       = ST_XM;
      end
      ST_XM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X_MIDDLE;
        cmd_o.acc_op  = ACC_PROD_D1;
        cmd_o.ld_xa   = 1'b1;
        state_d       = ST_RND;
      end
      ST_RND: begin
        if (!sts_i.out_busy) begin
          cmd_o.ld_y   = 1'b1;
          cmd_o.acc_op = ACC_PROD_D2;
          state_d      = ST_B1;
        end
      end
      ST_B1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y_BACK1;
        state_d       = ST_B2;
      end
      ST_B2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y_BACK2;
        cmd_o.acc_op  = ACC_SUB_PROD;
        state_d       = ST_W1;
      end
      ST_W1: begin
        cmd_o.wr_d1  = 1'b1;
        cmd_o.acc_op = ACC_XA_SUB_PROD;
        state_d      = ST_W2;
      end
      ST_W2: begin
        cmd_o.wr_d2 = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bq_datapath.sv =====
`timescale 1ns / 1ps

module bq_datapath import bq_pkg::*; #(
  parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic        [CHAN_WIDTH-1:0]   in_channel_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  logic                           cfg_we_i,
  input  logic        [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic        [COEF_WIDTH-1:0]   cfg_data_i,
  input  bq_cmd_t                        cmd_i,
  output bq_sts_t                        sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [CHAN_WIDTH-1:0]   out_channel_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_o
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = ((PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH) + 2;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] Y_MAX = (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - 1;
  localparam logic signed [SUM_W-1:0] D_MAX = (SUM_W'(1) <<< (ACC_WIDTH - 1)) - 1;
  localparam logic signed [SUM_W-1:0] D_MIN = -D_MAX - 1;

  logic signed [COEF_WIDTH-1:0]   c_outer_q, c_middle_q, c_back1_q, c_back2_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, y_d;
  logic        [CHAN_WIDTH-1:0]   ch_q, out_ch_q;
  logic        [IDX_W-1:0]        idx_q, idx_d;
  logic signed [PROD_W-1:0]       prod_q, prod_d, xa_q;
  logic signed [SUM_W-1:0]        acc_q, acc_d, rnd, quo, dsat;
  logic signed [ACC_WIDTH-1:0]    d1_q [NUM_CHANNELS];
  logic signed [ACC_WIDTH-1:0]    d2_q [NUM_CHANNELS];
  logic signed [ACC_WIDTH-1:0]    d1_rd, d2_rd;
  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEF_WIDTH-1:0]   mul_b;
  logic                           out_valid_q;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_outer_q  <= COEF_ONE;
      c_middle_q <= '0;
      c_back1_q  <= '0;
      c_back2_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FEED_OUTER:  c_outer_q  <= cfg_data_i;
        REG_FEED_MIDDLE: c_middle_q <= cfg_data_i;
        REG_BACK_FIRST:  c_back1_q  <= cfg_data_i;
        REG_BACK_SECOND: c_back2_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign idx_d = (NUM_CHANNELS == 1) ? '0 : IDX_W'(in_channel_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      x_q   <= in_sample_i;
      ch_q  <= in_channel_i;
      idx_q <= idx_d;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = x_q;
    mul_b = c_outer_q;
    case (cmd_i.mul_sel)
      MUL_X_OUTER:  begin mul_a = x_q; mul_b = c_outer_q;  end
      MUL_X_MIDDLE: begin mul_a = x_q; mul_b = c_middle_q; end
      MUL_Y_BACK1:  begin mul_a = y_q; mul_b = c_back1_q;  end
      MUL_Y_BACK2:  begin mul_a = y_q; mul_b = c_back2_q;  end
      default:      begin mul_a = x_q; mul_b = c_outer_q;  end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ld_xa) begin
      xa_q <= prod_q;
    end
  end

  assign d1_rd = d1_q[idx_q];
  assign d2_rd = d2_q[idx_q];

  // accumulator
  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD:        acc_d = acc_q;
      ACC_PROD_D1:     acc_d = SUM_W'(prod_q) + SUM_W'(d1_rd);
      ACC_PROD_D2:     acc_d = SUM_W'(prod_q) + SUM_W'(d2_rd);
      ACC_SUB_PROD:    acc_d = acc_q - SUM_W'(prod_q);
      ACC_XA_SUB_PROD: acc_d = SUM_W'(xa_q) - SUM_W'(prod_q);
      default:         acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // round half up, then saturate
  always_comb begin
    rnd = acc_q + HALF_LSB;
    quo = rnd >>> COEF_FRAC_BITS;
    if (quo > Y_MAX) begin
      y_d = SAMPLE_WIDTH'(Y_MAX);
    end else if (quo < Y_MIN) begin
      y_d = SAMPLE_WIDTH'(Y_MIN);
    end else begin
      y_d = SAMPLE_WIDTH'(quo);
    end
  end

  always_comb begin
    if (acc_q > D_MAX) begin
      dsat = D_MAX;
    end else if (acc_q < D_MIN) begin
      dsat = D_MIN;
    end else begin
      dsat = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else begin
      if (cmd_i.wr_d1) begin
        d1_q[idx_q] <= ACC_WIDTH'(dsat);
      end
      if (cmd_i.wr_d2) begin
        d2_q[idx_q] <= ACC_WIDTH'(dsat);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_y) begin
      y_q      <= y_d;
      out_ch_q <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_y) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign out_sample_o   = y_q;

endmodule

// ===== rtl/biquad_lowpass_tdf2_unit.sv =====
`timescale 1ns / 1ps
// Multi-channel biquad low-pass filter, transposed direct form II.
// in_i  : valid/ready channel carrying channel_in and a signed sample_in.
// out_o : valid/ready channel carrying channel_out and the filtered,
//         saturated sample_out; one result transaction per input transaction.
// cfg   : cfg_we_i writes cfg_data_i into coefficient cfg_idx_i
//         (0 outer feed-forward, 1 middle feed-forward, 2 and 3 feedback,
//         all Q3.22). Write only while the filter is idle.
// Sequence: the single shared multiplier (four products) and the accumulator
// sequence set the pace; a new input is accepted only once the last has
// finished its state update. The result is registered in the rounding
// step; the state update then finishes while the result waits to be taken.
// Stall: the result holds in the output register. A following input is
// still accepted and runs up to its rounding step, where it waits until
// the earlier result has been taken.
// Reset: coefficients return to pass-through (outer gain 1.0, others 0),
// both delay registers of every channel clear, the output channel empties.
module biquad_lowpass_tdf2_unit import bq_pkg::*; #(
  parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bq_in_if.sink                    in_i,
  bq_out_if.source                 out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]    cfg_data_i
);

  bq_cmd_t cmd;
  bq_sts_t sts;

  bq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bq_datapath #(
    .NUM_CHANNELS   (NUM_CHANNELS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_channel_i  (in_i.channel_in),
    .in_sample_i   (in_i.sample_in),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_channel_o (out_o.channel_out),
    .out_sample_o  (out_o.sample_out)
  );

endmodule

// ===== rtl/bq_checker.sv =====
`timescale 1ns / 1ps
`include "biquad_lowpass_tdf2_unit_defines.svh"

module bq_checker import bq_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [CHAN_WIDTH-1:0]   out_channel_i,
  input logic [SAMPLE_WIDTH-1:0] out_sample_i
);

  `BQ_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `BQ_ASSERT_NOW(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_i), !in_ready_i)
  `BQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_sample_i) && $stable(out_channel_i))

endmodule

bind biquad_lowpass_tdf2_unit bq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.channel_out),
  .out_sample_i  (out_o.sample_out)
);

// ===== sim/bq_tdf2_checker.sv =====
`timescale 1ns / 1ps

module bq_tdf2_checker import bq_pkg::*; #(
  parameter int NUM_CHANNELS   = DEF_NUM_CHANNELS,
  parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bq_in_if                         in_mon_i,
  bq_out_if                        out_mon_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]    cfg_data_i,
  output int unsigned              err_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  typedef struct packed {
    logic        [CHAN_WIDTH-1:0]   chan;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } filt_result_t;

  filt_result_t expected_q[$];

  logic signed [COEF_WIDTH-1:0] gain_outer, gain_middle, back_first, back_second;
  logic signed [ACC_WIDTH-1:0]  delay1 [NUM_CHANNELS];
  logic signed [ACC_WIDTH-1:0]  delay2 [NUM_CHANNELS];

  int unsigned err_count;
  int unsigned checked;

  function automatic longint sat_to(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one TDF-II step; updates the channel's delay pair
  function automatic filt_result_t filter_sample(logic [CHAN_WIDTH-1:0] chan,
                                                 logic signed [SAMPLE_WIDTH-1:0] x);
    int           idx;
    longint       xs, acc, y, n1, n2;
    filt_result_t r;
    idx = int'(chan) % NUM_CHANNELS;
    xs  = longint'(x);
    acc = xs * longint'(gain_outer) + longint'(delay1[idx]);
    y   = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    y   = sat_to(y, SAMPLE_WIDTH);
    n1  = xs * longint'(gain_middle) + longint'(delay2[idx]) - longint'(back_first) * y;
    n2  = xs * longint'(gain_outer) - longint'(back_second) * y;
    delay1[idx] = ACC_WIDTH'(sat_to(n1, ACC_WIDTH));
    delay2[idx] = ACC_WIDTH'(sat_to(n2, ACC_WIDTH));
    r.chan   = chan;
    r.sample = y[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_result_t got, want;
    if (!rst_ni) begin
      gain_outer  = COEF_WIDTH'(longint'(1) <<< COEF_FRAC_BITS);
      gain_middle = '0;
      back_first  = '0;
      back_second = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        delay1[c] = '0;
        delay2[c] = '0;
      end
      expected_q.delete();
      err_count = 0;
      checked   = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.chan   = out_mon_i.channel_out;
        got.sample = out_mon_i.sample_out;
        checked++;
        if (expected_q.size() == 0) begin
          if (err_count < 10)
            $display("chk: unexpected result ch %0d sample %0d", got.chan, got.sample);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            if (err_count < 10)
              $display("chk: result %0d: ch exp %0d got %0d, sample exp %0d got %0d",
                       checked, want.chan, got.chan, want.sample, got.sample);
            err_count++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        expected_q.push_back(filter_sample(in_mon_i.channel_in, in_mon_i.sample_in));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FEED_OUTER:  gain_outer  = cfg_data_i;
          REG_FEED_MIDDLE: gain_middle = cfg_data_i;
          REG_BACK_FIRST:  back_first  = cfg_data_i;
          REG_BACK_SECOND: back_second = cfg_data_i;
          default: ;
        endcase
      end
    end
    err_count_o = err_count;
    pending_o   = expected_q.size();
    checked_o   = checked;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bq_pkg::*;

  localparam int SW       = DEF_SAMPLE_WIDTH;
  localparam int FRAC     = DEF_COEF_FRAC_BITS;
  localparam int UNITY    = 1 << FRAC;
  localparam int SMP_MAX  = (1 << (SW - 1)) - 1;
  localparam int SMP_MIN  = -(1 << (SW - 1));
  localparam int COEF_MAX = (1 << (COEF_WIDTH - 1)) - 1;
  localparam int COEF_MIN = -(1 << (COEF_WIDTH - 1));

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx;
  logic [COEF_WIDTH-1:0]    cfg_data;

  int unsigned errors, pending, checked;
  int unsigned sent, settings;
  bit          calm;

  bq_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  bq_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  biquad_lowpass_tdf2_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bq_tdf2_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("tb: done, errors");
    $finish;
  end

  // result sink with random back-pressure
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_coefs(input int c_outer, c_middle, c_back1, c_back2);
    logic [COEF_WIDTH-1:0]    vals [4];
    logic [CFG_IDX_WIDTH-1:0] regs [4];
    vals = '{COEF_WIDTH'(c_outer), COEF_WIDTH'(c_middle),
             COEF_WIDTH'(c_back1), COEF_WIDTH'(c_back2)};
    regs = '{REG_FEED_OUTER, REG_FEED_MIDDLE, REG_BACK_FIRST, REG_BACK_SECOND};
    in_ch.valid <= 1'b0;
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[k];
      cfg_data <= vals[k];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_sample(input int ch, input int x);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.channel_in <= CHAN_WIDTH'(ch);
    in_ch.sample_in  <= SW'(x);
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = $urandom();
      6: v = int'($urandom_range(2000)) - 1000;
      7: v = $urandom_range(1) ? SMP_MAX : SMP_MIN;
      8: v = int'($urandom_range(2)) - 1;
      default: v = $urandom_range(1) ? SMP_MAX - int'($urandom_range(4095))
                                     : SMP_MIN + int'($urandom_range(4095));
    endcase
    return v[SW-1:0];
  endfunction

  function automatic logic [COEF_WIDTH-1:0] rand_coef();
    int v;
    case ($urandom_range(3))
      0: v = $urandom();
      1: v = int'($urandom_range(2 * UNITY)) - UNITY;
      2: v = $urandom_range(1) ? COEF_MAX : COEF_MIN;
      default: v = 0;
    endcase
    return v[COEF_WIDTH-1:0];
  endfunction

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.channel_in = '0;
    in_ch.sample_in  = '0;
    sent             = 0;
    settings         = 0;
    calm             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through after reset
    send_sample(0, SMP_MAX);
    send_sample(1, SMP_MIN);
    send_sample(0, 0);
    send_sample(1, -1);
    send_sample(0, 1);

    // gain 0.5: halves round toward plus infinity
    set_coefs(UNITY / 2, 0, 0, 0);
    send_sample(0, 1);
    send_sample(0, -1);
    send_sample(1, 3);
    send_sample(1, -3);

    // output saturation
    set_coefs(COEF_MAX, 0, 0, 0);
    send_sample(0, SMP_MAX);
    send_sample(1, SMP_MIN);
    send_sample(0, 1);

    // accumulator saturation
    set_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(0, SMP_MAX);
    send_sample(0, SMP_MAX);
    send_sample(1, SMP_MIN);
    send_sample(1, SMP_MIN);
    set_coefs(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
    send_sample(1, SMP_MAX);
    send_sample(1, SMP_MIN);
    send_sample(0, SMP_MAX);
    send_sample(0, SMP_MIN);

    for (int p = 0; p < 8; p++) begin
      calm = (p == 1) || (p == 6);
      case (p % 4)
        0: set_coefs(409494, 818988, -3954443, 1398101);  // fc = fs/8, Q = 0.707
        1: set_coefs(UNITY, 0, 0, 0);
        default: set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
      endcase
      for (int n = 0; n < 250; n++)
        send_sample(int'($urandom_range(1)), rand_sample());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    wait_idle();
    $display("tb: %0d samples sent over both channels, %0d results checked", sent, checked);
    $display("tb: %0d coefficient sets incl. pass-through, low-pass and saturating", settings);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== biquad_lowpass_tdf2_unit.f =====
+incdir+rtl
rtl/bq_pkg.sv
rtl/bq_if.sv
rtl/bq_ctrl.sv
rtl/bq_datapath.sv
rtl/biquad_lowpass_tdf2_unit.sv
rtl/bq_checker.sv
sim/bq_tdf2_checker.sv
sim/tb.sv
